// ===== hdl/hpd_pkg.sv =====
// ----------------------------------------------------------------------------
// hpd_pkg
// Types, constants and angle helpers for the heading PD controller.
// ----------------------------------------------------------------------------
package hpd_pkg;

  // payload types
  typedef logic        [12:0] heading_t;
  typedef logic signed [15:0] rate_t;
  typedef logic signed [9:0]  angle_t;
  typedef logic signed [12:0] bias_t;
  typedef logic signed [23:0] cmd_t;
  typedef logic signed [8:0]  deg_t;
  typedef logic        [15:0] gain_t;
  typedef logic signed [12:0] err_t;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_GAIN_P_CAMERA = 3'd0,
    REG_GAIN_D_CAMERA = 3'd1,
    REG_GAIN_P_GOALIE = 3'd2,
    REG_GAIN_D_GOALIE = 3'd3,
    REG_GAIN_P_NORMAL = 3'd4,
    REG_GAIN_D_NORMAL = 3'd5
  } reg_idx_t;

  // gain reset values, unsigned Q8.8 already divided by 4.5
  localparam gain_t GAIN_P_CAMERA_RST = 16'd273;
  localparam gain_t GAIN_D_CAMERA_RST = 16'd3413;
  localparam gain_t GAIN_P_GOALIE_RST = 16'd284;
  localparam gain_t GAIN_D_GOALIE_RST = 16'd2844;
  localparam gain_t GAIN_P_NORMAL_RST = 16'd626;
  localparam gain_t GAIN_D_NORMAL_RST = 16'd2844;

  // angle constants (whole degrees and 1/16 degree)
  localparam int DEG_HALF  = 180;
  localparam int DEG_FULL  = 360;
  localparam int FINE_HALF = 2880;
  localparam int FINE_FULL = 5760;

  // rounding and saturation of the command
  localparam int ROUND_HALF = 128;
  localparam int CMD_MAX    = 8388607;
  localparam int CMD_MIN    = -8388608;

  // input sample as held in the pipeline
  typedef struct packed {
    heading_t heading;
    rate_t    yaw_rate;
    logic     capture_offset;
    logic     camera_valid;
    logic     has_ball;
    logic     goalie;
    angle_t   front_target_angle;
    angle_t   rear_target_angle;
    bias_t    turn_bias;
  } sample_t;

  // wrap whole degrees into [-180,180), one period is enough for the input span
  function automatic deg_t wrap_deg(logic signed [10:0] x);
    logic signed [10:0] y;
    begin
      if (x > DEG_HALF - 1) begin
        y = 11'(x - DEG_FULL);
      end else if (x < -DEG_HALF) begin
        y = 11'(x + DEG_FULL);
      end else begin
        y = x;
      end
      return y[8:0];
    end
  endfunction

  // wrap 1/16 degree into [-2880,2880], up to two periods each way
  function automatic err_t wrap_fine(logic signed [15:0] x);
    logic signed [15:0] a;
    logic signed [15:0] b;
    begin
      if (x > FINE_HALF + FINE_FULL) begin
        a = 16'(x - 2 * FINE_FULL);
      end else if (x > FINE_HALF) begin
        a = 16'(x - FINE_FULL);
      end else begin
        a = x;
      end
      if (a < -FINE_HALF - FINE_FULL) begin
        b = 16'(a + 2 * FINE_FULL);
      end else if (a < -FINE_HALF) begin
        b = 16'(a + FINE_FULL);
      end else begin
        b = a;
      end
      return b[12:0];
    end
  endfunction

endpackage

// ===== hdl/hpd_if.sv =====
// ----------------------------------------------------------------------------
// hpd_if
// Valid/ready channels for samples in and commands out.
// ----------------------------------------------------------------------------
interface hpd_sample_if import hpd_pkg::*; ();
  logic     valid;
  logic     ready;
  heading_t heading;
  rate_t    yaw_rate;
  logic     capture_offset;
  logic     camera_valid;
  logic     has_ball;
  logic     goalie;
  angle_t   front_target_angle;
  angle_t   rear_target_angle;
  bias_t    turn_bias;

  modport source (
    output valid, heading, yaw_rate, capture_offset, camera_valid, has_ball, goalie,
           front_target_angle, rear_target_angle, turn_bias,
    input  ready
  );
  modport sink (
    input  valid, heading, yaw_rate, capture_offset, camera_valid, has_ball, goalie,
           front_target_angle, rear_target_angle, turn_bias,
    output ready
  );
endinterface

interface hpd_result_if import hpd_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t rotation_cmd;
  deg_t heading_error_deg;

  modport source (output valid, rotation_cmd, heading_error_deg, input ready);
  modport sink (input valid, rotation_cmd, heading_error_deg, output ready);
endinterface

// ===== hdl/heading_pd_controller.sv =====
// Path: an accepted sample passes the input, error and result registers in order.
// Throughput: one sample per cycle; the three pipeline registers stall together
// only while a finished result waits to be taken.
// Reset: clears all valid flags and the heading offset, and loads the gain
// registers with their default values.
// ----------------------------------------------------------------------------
// heading_pd_controller
// Heading PD controller with angle wrap: mode select, error wrap, PD product.
// ----------------------------------------------------------------------------
module heading_pd_controller import hpd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // channels
  hpd_sample_if.sink        sample,
  hpd_result_if.source      result
);

  // gain registers
  gain_t gain_p_camera;
  gain_t gain_d_camera;
  gain_t gain_p_goalie;
  gain_t gain_d_goalie;
  gain_t gain_p_normal;
  gain_t gain_d_normal;

  // pipeline state
  logic     adv;
  logic     s1_valid;
  sample_t  s1;
  heading_t heading_offset;
  logic     s2_valid;
  err_t     s2_err;
  gain_t    s2_kp;
  gain_t    s2_kd;
  rate_t    s2_rate;
  logic     out_valid;
  cmd_t     out_cmd;
  deg_t     out_deg;

  // configuration decode
  reg_idx_t cfg_idx;
  logic     cfg_wr;

  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p_camera <= GAIN_P_CAMERA_RST;
      gain_d_camera <= GAIN_D_CAMERA_RST;
      gain_p_goalie <= GAIN_P_GOALIE_RST;
      gain_d_goalie <= GAIN_D_GOALIE_RST;
      gain_p_normal <= GAIN_P_NORMAL_RST;
      gain_d_normal <= GAIN_D_NORMAL_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GAIN_P_CAMERA: gain_p_camera <= pwdata[15:0];
        REG_GAIN_D_CAMERA: gain_d_camera <= pwdata[15:0];
        REG_GAIN_P_GOALIE: gain_p_goalie <= pwdata[15:0];
        REG_GAIN_D_GOALIE: gain_d_goalie <= pwdata[15:0];
        REG_GAIN_P_NORMAL: gain_p_normal <= pwdata[15:0];
        REG_GAIN_D_NORMAL: gain_d_normal <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      REG_GAIN_P_CAMERA: prdata = {16'd0, gain_p_camera};
      REG_GAIN_D_CAMERA: prdata = {16'd0, gain_d_camera};
      REG_GAIN_P_GOALIE: prdata = {16'd0, gain_p_goalie};
      REG_GAIN_D_GOALIE: prdata = {16'd0, gain_d_goalie};
      REG_GAIN_P_NORMAL: prdata = {16'd0, gain_p_normal};
      REG_GAIN_D_NORMAL: prdata = {16'd0, gain_d_normal};
      default:           prdata = '0;
    endcase
  end

  // whole pipeline moves unless the result register is full and held
  assign adv          = !(out_valid && !result.ready);
  assign sample.ready = adv;

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && sample.valid) begin
      s1.heading            <= sample.heading;
      s1.yaw_rate           <= sample.yaw_rate;
      s1.capture_offset     <= sample.capture_offset;
      s1.camera_valid       <= sample.camera_valid;
      s1.has_ball           <= sample.has_ball;
      s1.goalie             <= sample.goalie;
      s1.front_target_angle <= sample.front_target_angle;
      s1.rear_target_angle  <= sample.rear_target_angle;
      s1.turn_bias          <= sample.turn_bias;
    end
  end

  // error formation
  heading_t           off_eff;
  logic signed [13:0] rel;
  logic signed [13:0] rel_adj;
  logic signed [10:0] rel_deg;
  logic signed [10:0] tgt_neg;
  deg_t               t_w;
  deg_t               r_w;
  logic signed [9:0]  diff;
  logic signed [15:0] x_cam;
  logic signed [15:0] x_norm;
  logic signed [15:0] x_sel;
  logic               cam_mode;
  err_t               err;
  gain_t              kp_sel;
  gain_t              kd_sel;

  always_comb begin
    // capture applies to the same sample
    off_eff  = s1.capture_offset ? s1.heading : heading_offset;
    rel      = $signed({1'b0, s1.heading}) - $signed({1'b0, off_eff});
    // divide by 16, truncating toward zero
    rel_adj  = rel[13] ? 14'(rel + 14'sd15) : rel;
    rel_deg  = 11'(rel_adj >>> 4);
    cam_mode = s1.camera_valid && s1.has_ball;
    tgt_neg  = cam_mode ? -11'(s1.front_target_angle) : -11'(s1.rear_target_angle);
    t_w      = wrap_deg(tgt_neg);
    r_w      = wrap_deg(rel_deg);
    diff     = 10'(t_w) - 10'(r_w);
    x_cam    = $signed({3'b000, s1.heading}) + (16'(diff) <<< 4);
    x_norm   = 16'(rel) + 16'(s1.turn_bias);
    // mode priority: camera, goalie, normal
    priority if (cam_mode) begin
      x_sel  = x_cam;
      kp_sel = gain_p_camera;
      kd_sel = gain_d_camera;
    end else if (s1.goalie) begin
      x_sel  = x_cam;
      kp_sel = gain_p_goalie;
      kd_sel = gain_d_goalie;
    end else begin
      x_sel  = x_norm;
      kp_sel = gain_p_normal;
      kd_sel = gain_d_normal;
    end
    err = wrap_fine(x_sel);
  end

  // stage 2: error and selected gains, offset update
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid       <= 1'b0;
      heading_offset <= '0;
    end else if (adv) begin
      s2_valid <= s1_valid;
      if (s1_valid && s1.capture_offset) begin
        heading_offset <= s1.heading;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      s2_err  <= err;
      s2_kp   <= kp_sel;
      s2_kd   <= kd_sel;
      s2_rate <= s1.yaw_rate;
    end
  end

  // pd product, round half up, saturate
  logic signed [32:0] prod_d;
  logic signed [29:0] prod_p;
  logic signed [33:0] raw;
  logic signed [25:0] shifted;
  cmd_t               cmd;
  logic signed [12:0] err_adj;
  deg_t               deg;

  always_comb begin
    prod_d  = $signed({1'b0, s2_kd}) * s2_rate;
    prod_p  = $signed({1'b0, s2_kp}) * s2_err;
    raw     = 34'(prod_d) - 34'(prod_p) + 34'(ROUND_HALF);
    shifted = 26'(raw >>> 8);
    if (shifted > CMD_MAX) begin
      cmd = 24'(CMD_MAX);
    end else if (shifted < CMD_MIN) begin
      cmd = 24'(CMD_MIN);
    end else begin
      cmd = shifted[23:0];
    end
    err_adj = s2_err[12] ? 13'(s2_err + 13'sd15) : s2_err;
    deg     = 9'(err_adj >>> 4);
  end

  // stage 3: result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      out_cmd <= cmd;
      out_deg <= deg;
    end
  end

  assign result.valid             = out_valid;
  assign result.rotation_cmd      = out_cmd;
  assign result.heading_error_deg = out_deg;

`ifndef ASSERT_OFF
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (s2_err >= -FINE_HALF && s2_err <= FINE_HALF))
    else $error("wrapped error out of range");

  a_deg_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.heading_error_deg >= -DEG_HALF &&
                      result.heading_error_deg <= DEG_HALF))
    else $error("heading error degrees out of range");

  a_offset_capture: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_valid && s1.capture_offset) |=> (heading_offset == $past(s1.heading)))
    else $error("heading offset not captured");

  a_zero_cmd: assert property (@(posedge clk) disable iff (rst)
    (adv && s2_valid && s2_err == '0 && s2_rate == '0) |=> (out_cmd == '0))
    else $error("zero error and rate gave non-zero command");
`endif

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the heading PD controller. A short table of
// directed samples covers field extremes, every mode, offset capture and the
// wrap corner cases; random samples follow under several gain settings. Each
// accepted sample is run through a local model of the controller and the
// command transactions are compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import hpd_pkg::*;

  localparam int PIPE_DEPTH   = 3;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_AT      = 700;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 220;
  localparam int TAIL_ITEMS   = 100;

  typedef enum int {
    GAINS_DEFAULT,
    GAINS_MAX,
    GAINS_ZERO,
    GAINS_RANDOM
  } gain_set_t;

  typedef struct {
    cmd_t cmd;
    deg_t deg;
  } turn_t;

  typedef struct {
    sample_t s;
    bit      max_gains;
    bit      pinned;
    cmd_t    cmd;
    deg_t    deg;
  } probe_t;

  logic clk;
  logic rst;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  hpd_sample_if samples_in ();
  hpd_result_if turns_out ();

  // typed-in expectation travelling with the offered sample
  logic pin_valid;
  cmd_t pin_cmd;
  deg_t pin_deg;

  // local copy of the controller state
  gain_t    gain_mirror [6];
  heading_t heading_ofs = '0;

  turn_t  pending_turns [$];
  probe_t probes [$];

  int fail_count   = 0;
  int accepted_in  = 0;
  int quiet_cycles = 0;
  bit steady       = 1'b0;
  bit gaps_on      = 1'b1;
  bit held         = 1'b0;

  heading_pd_controller DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (samples_in),
    .result  (turns_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // fold whole degrees into [-180,180)
  function automatic longint fold_degrees(input longint a);
    while (a > DEG_HALF - 1) a -= DEG_FULL;
    while (a < -DEG_HALF) a += DEG_FULL;
    return a;
  endfunction

  // heading error and rotation command for one sample, updates the offset
  function automatic void predict_turn(input sample_t s, output cmd_t cmd, output deg_t deg);
    longint head, rate, rel, x, tgt, kp, kd, raw, q;
    bit     cam_mode;
    head     = longint'(s.heading);
    rate     = longint'($signed(s.yaw_rate));
    cam_mode = s.camera_valid && s.has_ball;
    if (s.capture_offset) begin
      heading_ofs = s.heading;
    end
    rel = head - longint'(heading_ofs);
    if (cam_mode || s.goalie) begin
      tgt = cam_mode ? longint'($signed(s.front_target_angle))
                     : longint'($signed(s.rear_target_angle));
      x = head + 16 * (fold_degrees(-tgt) - fold_degrees(rel / 16));
      kp = cam_mode ? gain_mirror[REG_GAIN_P_CAMERA] : gain_mirror[REG_GAIN_P_GOALIE];
      kd = cam_mode ? gain_mirror[REG_GAIN_D_CAMERA] : gain_mirror[REG_GAIN_D_GOALIE];
    end else begin
      x  = rel + longint'($signed(s.turn_bias));
      kp = gain_mirror[REG_GAIN_P_NORMAL];
      kd = gain_mirror[REG_GAIN_D_NORMAL];
    end
    // error wrap: -2880 reached from below stays there
    while (x > FINE_HALF) x -= FINE_FULL;
    while (x < -FINE_HALF) x += FINE_FULL;
    raw = kd * rate - kp * x;
    q   = (raw + ROUND_HALF) >>> 8;
    if (q > CMD_MAX) q = CMD_MAX;
    if (q < CMD_MIN) q = CMD_MIN;
    cmd = cmd_t'(q);
    deg = deg_t'(x / 16);
  endfunction

  function automatic gain_t default_gain(input reg_idx_t idx);
    case (idx)
      REG_GAIN_P_CAMERA: return GAIN_P_CAMERA_RST;
      REG_GAIN_D_CAMERA: return GAIN_D_CAMERA_RST;
      REG_GAIN_P_GOALIE: return GAIN_P_GOALIE_RST;
      REG_GAIN_D_GOALIE: return GAIN_D_GOALIE_RST;
      REG_GAIN_P_NORMAL: return GAIN_P_NORMAL_RST;
      default:           return GAIN_D_NORMAL_RST;
    endcase
  endfunction

  function automatic void add_row(input int h, input int rate, input bit cap, input bit cam,
                                  input bit ball, input bit gk, input int front,
                                  input int rear, input int bias, input bit max_gains,
                                  input bit pinned, input int cmd, input int deg);
    probe_t p;
    p.s.heading            = heading_t'(h);
    p.s.yaw_rate           = rate_t'(rate);
    p.s.capture_offset     = cap;
    p.s.camera_valid       = cam;
    p.s.has_ball           = ball;
    p.s.goalie             = gk;
    p.s.front_target_angle = angle_t'(front);
    p.s.rear_target_angle  = angle_t'(rear);
    p.s.turn_bias          = bias_t'(bias);
    p.max_gains            = max_gains;
    p.pinned               = pinned;
    p.cmd                  = cmd_t'(cmd);
    p.deg                  = deg_t'(deg);
    probes.push_back(p);
  endfunction

  // random sample, mostly in the nominal ranges, modes evenly spread
  function automatic sample_t draw_sample();
    sample_t s;
    int      pick;
    s.heading = ($urandom_range(7) == 0) ? heading_t'($urandom_range(8191))
                                         : heading_t'($urandom_range(5759));
    pick = $urandom_range(9);
    if (pick == 0) begin
      s.yaw_rate = rate_t'(32767);
    end else if (pick == 1) begin
      s.yaw_rate = rate_t'(-32768);
    end else begin
      s.yaw_rate = rate_t'($urandom);
    end
    s.capture_offset = ($urandom_range(9) == 0);
    pick = $urandom_range(2);
    if (pick == 0) begin
      s.camera_valid = 1'b1;
      s.has_ball     = 1'b1;
      s.goalie       = 1'($urandom_range(1));
    end else begin
      case ($urandom_range(2))
        0:       {s.camera_valid, s.has_ball} = 2'b00;
        1:       {s.camera_valid, s.has_ball} = 2'b10;
        default: {s.camera_valid, s.has_ball} = 2'b01;
      endcase
      s.goalie = (pick == 1);
    end
    s.front_target_angle = ($urandom_range(3) == 0) ? angle_t'($urandom)
                                                    : angle_t'(int'($urandom_range(360)) - 180);
    s.rear_target_angle  = ($urandom_range(3) == 0) ? angle_t'($urandom)
                                                    : angle_t'(int'($urandom_range(360)) - 180);
    s.turn_bias          = ($urandom_range(3) == 0) ? bias_t'($urandom)
                                                    : bias_t'(int'($urandom_range(5760)) - 2880);
    return s;
  endfunction

  // offer one sample and hold it until the transaction completes
  task automatic offer_sample(input sample_t s, input bit pinned, input cmd_t c,
                              input deg_t d);
    samples_in.valid              <= 1'b1;
    samples_in.heading            <= s.heading;
    samples_in.yaw_rate           <= s.yaw_rate;
    samples_in.capture_offset     <= s.capture_offset;
    samples_in.camera_valid       <= s.camera_valid;
    samples_in.has_ball           <= s.has_ball;
    samples_in.goalie             <= s.goalie;
    samples_in.front_target_angle <= s.front_target_angle;
    samples_in.rear_target_angle  <= s.rear_target_angle;
    samples_in.turn_bias          <= s.turn_bias;
    pin_valid                     <= pinned;
    pin_cmd                       <= c;
    pin_deg                       <= d;
    @(posedge clk);
    while (!samples_in.ready) @(posedge clk);
  endtask

  task automatic pause_sender();
    if (!steady && gaps_on && $urandom_range(3) == 0) begin
      samples_in.valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every command is back
  task automatic settle();
    samples_in.valid <= 1'b0;
    @(posedge clk);
    while (pending_turns.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  // register write: setup phase, then access phase
  task automatic write_gain(input reg_idx_t idx, input gain_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) * 4);
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    gain_mirror[idx] = value;
    @(posedge clk);
  endtask

  task automatic apply_gain_set(input gain_set_t set);
    reg_idx_t idx;
    gain_t    v;
    settle();
    for (int i = 0; i <= int'(REG_GAIN_D_NORMAL); i++) begin
      idx = reg_idx_t'(i);
      case (set)
        GAINS_MAX:    v = '1;
        GAINS_ZERO:   v = '0;
        GAINS_RANDOM: v = gain_t'($urandom);
        default:      v = default_gain(idx);
      endcase
      write_gain(idx, v);
    end
  endtask

  task automatic run_phase(input gain_set_t set, input bit last);
    apply_gain_set(set);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (last && PHASE_ITEMS - i <= TAIL_ITEMS) begin
        steady = 1'b1;
      end
      if (i % 64 == 0) begin
        gaps_on = 1'($urandom_range(1));
      end
      offer_sample(draw_sample(), 1'b0, '0, '0);
      pause_sender();
    end
  endtask

  // main sequence
  initial begin
    samples_in.valid              <= 1'b0;
    samples_in.heading            <= '0;
    samples_in.yaw_rate           <= '0;
    samples_in.capture_offset     <= 1'b0;
    samples_in.camera_valid       <= 1'b0;
    samples_in.has_ball           <= 1'b0;
    samples_in.goalie             <= 1'b0;
    samples_in.front_target_angle <= '0;
    samples_in.rear_target_angle  <= '0;
    samples_in.turn_bias          <= '0;
    pin_valid                     <= 1'b0;
    pin_cmd                       <= '0;
    pin_deg                       <= '0;
    psel                          <= 1'b0;
    penable                       <= 1'b0;
    pwrite                        <= 1'b0;
    paddr                         <= '0;
    pwdata                        <= '0;
    rst                           <= 1'b1;
    for (int i = 0; i <= int'(REG_GAIN_D_NORMAL); i++) begin
      gain_mirror[i] = default_gain(reg_idx_t'(i));
    end

    //      head  rate cap cam ball gk front rear  bias  max pin  cmd  deg
    add_row(0,       0, 0, 0, 0, 0,    0,   0,     0, 0, 1,     0,    0);
    add_row(0,       0, 0, 0, 0, 0,    0,   0,  2880, 0, 1, -7042,  180);
    add_row(0,       0, 0, 0, 0, 0,    0,   0, -2880, 0, 1,  7043, -180);
    add_row(0,   32767, 0, 0, 0, 0,    0,   0,  4095, 0, 0,     0,    0);
    add_row(0,  -32768, 0, 0, 0, 0,    0,   0, -4096, 0, 0,     0,    0);
    add_row(8191, 1234, 0, 0, 0, 0,    0,   0,     0, 0, 0,     0,    0);
    // capture: offset equals heading, so the error is zero
    add_row(8191,    0, 1, 0, 0, 0,    0,   0,     0, 0, 1,     0,    0);
    // error of -180 reached from below stays at -180
    add_row(0,       0, 0, 0, 0, 0,    0,   0,  -449, 0, 0,     0,    0);
    add_row(0,      -1, 0, 0, 0, 0,    0,   0, -4096, 0, 0,     0,    0);
    add_row(0,       0, 1, 0, 0, 0,    0,   0,     0, 0, 0,     0,    0);
    // +180 from above folds down to +180
    add_row(8191,    0, 0, 0, 0, 0,    0,   0,   449, 0, 0,     0,    0);
    add_row(100, -32768, 0, 1, 1, 0, -512,   0,     0, 0, 0,     0,    0);
    add_row(5759, 32767, 0, 1, 1, 0,  511,   0,     0, 0, 0,     0,    0);
    // camera without ball falls back to normal
    add_row(200,    77, 0, 1, 0, 0,    0,   0,   100, 0, 0,     0,    0);
    add_row(300,   -77, 0, 0, 1, 1,    0, -512,    0, 0, 0,     0,    0);
    add_row(3000,  500, 0, 0, 0, 1,    0,  511,    0, 0, 0,     0,    0);
    // camera mode beats goalie
    add_row(1000, -500, 0, 1, 1, 1,  180,   7,     0, 0, 0,     0,    0);
    // capture applies to the same camera sample
    add_row(5759,   10, 1, 1, 1, 0, -180,   0,     0, 0, 0,     0,    0);
    add_row(0,       0, 0, 0, 0, 1,    0,   0,     0, 0, 0,     0,    0);
    // heading beyond a full turn
    add_row(5760,    0, 0, 0, 0, 0,    0,   0,     0, 0, 0,     0,    0);
    // command saturation at full gains
    add_row(0,   32767, 1, 0, 0, 0,    0,   0, -2880, 1, 1, CMD_MAX, -180);
    add_row(0,  -32768, 0, 0, 0, 0,    0,   0,  2880, 1, 1, CMD_MIN,  180);
    add_row(0,   32767, 0, 1, 1, 0,    0,   0,     0, 1, 0,     0,    0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table
    begin : directed
      bit at_max;
      at_max = 1'b0;
      foreach (probes[i]) begin
        if (probes[i].max_gains != at_max) begin
          at_max = probes[i].max_gains;
          apply_gain_set(at_max ? GAINS_MAX : GAINS_DEFAULT);
        end
        offer_sample(probes[i].s, probes[i].pinned, probes[i].cmd, probes[i].deg);
        pause_sender();
      end
    end

    // random part under several gain settings
    run_phase(GAINS_DEFAULT, 1'b0);
    run_phase(GAINS_MAX, 1'b0);
    run_phase(GAINS_ZERO, 1'b0);
    run_phase(GAINS_RANDOM, 1'b0);
    run_phase(GAINS_RANDOM, 1'b1);

    settle();
    if (fail_count == 0) begin
      $display("** heading_pd_controller: PASSED **");
    end else begin
      $display("** heading_pd_controller: FAILED **");
    end
    $finish;
  end

  // command receiver with random stalls and one long hold-off
  initial begin
    turns_out.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && accepted_in >= HOLD_AT) begin
        held = 1'b1;
        turns_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!steady && $urandom_range(2) == 0) begin
        turns_out.ready <= 1'b0;
        repeat ($urandom_range(10, 1)) @(posedge clk);
      end
      turns_out.ready <= 1'b1;
      repeat ($urandom_range(40, 1)) @(posedge clk);
    end
  end

  // transaction monitor, checker and watchdog
  always @(posedge clk) begin : track
    sample_t seen;
    cmd_t    want_cmd;
    deg_t    want_deg;
    turn_t   oldest;
    bit      moved;
    moved = 1'b0;

    // sample transaction: predict and queue its command
    if (!rst && samples_in.valid && samples_in.ready) begin
      seen = '{heading:            samples_in.heading,
               yaw_rate:           samples_in.yaw_rate,
               capture_offset:     samples_in.capture_offset,
               camera_valid:       samples_in.camera_valid,
               has_ball:           samples_in.has_ball,
               goalie:             samples_in.goalie,
               front_target_angle: samples_in.front_target_angle,
               rear_target_angle:  samples_in.rear_target_angle,
               turn_bias:          samples_in.turn_bias};
      predict_turn(seen, want_cmd, want_deg);
      if (pin_valid) begin
        want_cmd = pin_cmd;
        want_deg = pin_deg;
      end
      pending_turns.push_back('{cmd: want_cmd, deg: want_deg});
      accepted_in++;
      moved = 1'b1;
    end

    // command transaction: compare with the oldest prediction
    if (!rst && turns_out.valid && turns_out.ready) begin
      moved = 1'b1;
      if (pending_turns.size() == 0) begin
        $error("command transaction with nothing pending: rotation_cmd %0d heading_error_deg %0d",
               turns_out.rotation_cmd, turns_out.heading_error_deg);
        fail_count++;
      end else begin
        oldest = pending_turns.pop_front();
        if (turns_out.rotation_cmd !== oldest.cmd) begin
          $error("rotation_cmd: expected %0d, got %0d", oldest.cmd, turns_out.rotation_cmd);
          fail_count++;
        end
        if (turns_out.heading_error_deg !== oldest.deg) begin
          $error("heading_error_deg: expected %0d, got %0d", oldest.deg,
                 turns_out.heading_error_deg);
          fail_count++;
        end
      end
    end

    // watchdog on cycles without any transaction
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** heading_pd_controller: FAILED **");
      $finish;
    end
  end

endmodule
